>>> sv/sfb_pkg.sv
// Package for the stuffed frame builder: register map, reset values,
// configuration struct and the byte-stuffing helper.
// No dependencies.
`default_nettype none

package sfb_pkg;

  // Register map, one 8-bit register per 32-bit word.
  typedef enum logic [2:0] {
    RegFlag      = 3'd0,
    RegEscape    = 3'd1,
    RegFlagSub   = 3'd2,
    RegEscSub    = 3'd3,
    RegAddress   = 3'd4,
    RegCtlZero   = 3'd5,
    RegCtlOne    = 3'd6
  } reg_idx_e;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Reset values of the configuration registers.
  localparam logic [7:0] FlagReset    = 8'd126;
  localparam logic [7:0] EscapeReset  = 8'd125;
  localparam logic [7:0] FlagSubReset = 8'd94;
  localparam logic [7:0] EscSubReset  = 8'd93;
  localparam logic [7:0] AddrReset    = 8'd3;
  localparam logic [7:0] CtlZeroReset = 8'd0;
  localparam logic [7:0] CtlOneReset  = 8'd64;

  // Most line bytes one input beat can produce, and the slot index width.
  localparam int unsigned MaxSlots = 9;
  localparam int unsigned SlotW    = $clog2(MaxSlots);

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] flag_sub;
    logic [7:0] esc_sub;
    logic [7:0] address;
    logic [7:0] ctl_zero;
    logic [7:0] ctl_one;
  } cfg_t;

  // One stuffed byte: either a single byte or an escape pair.
  typedef struct packed {
    logic       two;
    logic [7:0] first;
    logic [7:0] second;
  } stuff_t;

  // The flag test wins when flag and escape hold the same value.
  function automatic stuff_t stuff_byte(logic [7:0] b, cfg_t cfg);
    stuff_t s;
    s.two    = 1'b1;
    s.first  = cfg.escape;
    s.second = b;
    if (b == cfg.flag) begin
      s.second = cfg.flag_sub;
    end else if (b == cfg.escape) begin
      s.second = cfg.esc_sub;
    end else begin
      s.two   = 1'b0;
      s.first = b;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> sv/sfb_cfg_regs.sv
// Configuration register file of the stuffed frame builder, APB-style port.
// Depends on sfb_pkg.
`default_nettype none

module sfb_cfg_regs
  import sfb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic [7:0] rd_byte;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  // Register writes; an address past the last register is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag     <= FlagReset;
      cfg_q.escape   <= EscapeReset;
      cfg_q.flag_sub <= FlagSubReset;
      cfg_q.esc_sub  <= EscSubReset;
      cfg_q.address  <= AddrReset;
      cfg_q.ctl_zero <= CtlZeroReset;
      cfg_q.ctl_one  <= CtlOneReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegFlag:    cfg_q.flag     <= pwdata[7:0];
        RegEscape:  cfg_q.escape   <= pwdata[7:0];
        RegFlagSub: cfg_q.flag_sub <= pwdata[7:0];
        RegEscSub:  cfg_q.esc_sub  <= pwdata[7:0];
        RegAddress: cfg_q.address  <= pwdata[7:0];
        RegCtlZero: cfg_q.ctl_zero <= pwdata[7:0];
        RegCtlOne:  cfg_q.ctl_one  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      RegFlag:    rd_byte = cfg_q.flag;
      RegEscape:  rd_byte = cfg_q.escape;
      RegFlagSub: rd_byte = cfg_q.flag_sub;
      RegEscSub:  rd_byte = cfg_q.esc_sub;
      RegAddress: rd_byte = cfg_q.address;
      RegCtlZero: rd_byte = cfg_q.ctl_zero;
      RegCtlOne:  rd_byte = cfg_q.ctl_one;
      default:    rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(DataW-8){1'b0}}, rd_byte};
  assign cfg_o  = cfg_q;

endmodule

`default_nettype wire

>>> sv/stuffed_frame_builder_unit.sv
// Stuffed frame builder: an input beat is turned into 1 to 9 line bytes in one
// pass and held in a slot register, shifted out one byte per cycle unless stalled.
// Latency: the first byte of a beat is offered in the cycle after acceptance.
// A beat's bytes leave one per accepted output transfer, and the
// next beat is taken in the cycle its predecessor's last byte leaves.
// Reset: frame closed, check cleared, slot register empty, registers at defaults.
`default_nettype none

module stuffed_frame_builder_unit
  import sfb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration port.
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  // Input channel.
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       payload_byte_i,
  input  wire logic             seq_bit_i,
  input  wire logic             last_byte_i,
  input  wire logic             empty_frame_i,
  // Output channel.
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [7:0]       out_byte_o,
  output logic                  end_of_run_o,
  output logic                  frame_end_o
);

  cfg_t cfg;

  sfb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Frame state.
  logic       frame_open_q, frame_open_d;
  logic [7:0] check_q, check_d;

  // Slot register holding the bytes of one beat.
  logic [7:0]       slots_q [MaxSlots];
  logic [7:0]       slots_d [MaxSlots];
  logic [SlotW-1:0] idx_q, last_idx_q, last_idx_d;
  logic             hold_q, close_q, close_d;

  logic             in_fire, at_last, take_last;
  logic             need_hdr, closes;
  logic [7:0]       ctl, chk;
  logic [SlotW-1:0] n;
  stuff_t           st_pay, st_chk;

  assign at_last    = (idx_q == last_idx_q);
  assign take_last  = hold_q && out_ready_i && at_last;
  assign in_ready_o = !hold_q || take_last;
  assign in_fire    = in_valid_i && in_ready_o;

  // Build the line bytes of the incoming beat.
  always_comb begin
    need_hdr     = empty_frame_i || !frame_open_q;
    closes       = empty_frame_i || last_byte_i;
    ctl          = seq_bit_i ? cfg.ctl_one : cfg.ctl_zero;
    chk          = empty_frame_i ? 8'd0 : (check_q ^ payload_byte_i);
    st_pay       = stuff_byte(payload_byte_i, cfg);
    st_chk       = stuff_byte(chk, cfg);
    frame_open_d = frame_open_q;
    check_d      = check_q;
    n            = '0;
    for (int i = 0; i < MaxSlots; i++) begin
      slots_d[i] = 8'd0;
    end
    // Header: flag, address, control, header check.
    if (need_hdr) begin
      slots_d[0] = cfg.flag;
      slots_d[1] = cfg.address;
      slots_d[2] = ctl;
      slots_d[3] = cfg.address ^ ctl;
      n          = SlotW'(4);
    end
    // Stuffed payload byte.
    if (!empty_frame_i) begin
      slots_d[n] = st_pay.first;
      n          = n + SlotW'(1);
      if (st_pay.two) begin
        slots_d[n] = st_pay.second;
        n          = n + SlotW'(1);
      end
    end
    // Stuffed check and closing flag.
    if (closes) begin
      slots_d[n] = st_chk.first;
      n          = n + SlotW'(1);
      if (st_chk.two) begin
        slots_d[n] = st_chk.second;
        n          = n + SlotW'(1);
      end
      slots_d[n] = cfg.flag;
      n          = n + SlotW'(1);
    end
    last_idx_d = n - SlotW'(1);
    close_d    = closes;
    // Frame state after this beat.
    if (closes) begin
      frame_open_d = 1'b0;
      check_d      = 8'd0;
    end else begin
      frame_open_d = 1'b1;
      check_d      = chk;
    end
  end

  // Control registers: frame state, slot occupancy and read index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      check_q      <= 8'd0;
      hold_q       <= 1'b0;
      idx_q        <= '0;
      last_idx_q   <= '0;
      close_q      <= 1'b0;
    end else if (in_fire) begin
      frame_open_q <= frame_open_d;
      check_q      <= check_d;
      hold_q       <= 1'b1;
      idx_q        <= '0;
      last_idx_q   <= last_idx_d;
      close_q      <= close_d;
    end else if (hold_q && out_ready_i) begin
      if (at_last) begin
        hold_q <= 1'b0;
      end else begin
        idx_q <= idx_q + SlotW'(1);
      end
    end
  end

  // Slot payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      slots_q <= slots_d;
    end
  end

  assign out_valid_o  = hold_q;
  assign out_byte_o   = slots_q[idx_q];
  assign end_of_run_o = at_last;
  assign frame_end_o  = at_last && close_q;

`ifndef SYNTHESIS
  // The read index never runs past the last filled slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> (idx_q <= last_idx_q))
    else $error("read index past last slot");

  // A beat that closes a frame leaves the frame closed with a cleared check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (empty_frame_i || last_byte_i)) |=> (!frame_open_q && (check_q == 8'd0)))
    else $error("frame state not cleared after close");

  // A new beat is taken only when the slot register is free or emptying.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && hold_q) |-> (out_ready_i && at_last))
    else $error("beat accepted over pending bytes");
`endif

endmodule

`default_nettype wire
